/* design/gsat_pkg.sv */
package gsat_pkg;

	// Configuration register indexes
	localparam logic [1:0] RegFrameWidth  = 2'd0;
	localparam logic [1:0] RegFrameHeight = 2'd1;

	localparam int CfgIndexW = 2;
	localparam int CfgDataW  = 12;
	localparam int Channels  = 4;
	localparam int LinW      = 8;
	localparam int SumW      = 32;

	typedef logic [Channels-1:0][LinW-1:0] lin_vec_t;
	typedef logic [Channels-1:0][SumW-1:0] sum_vec_t;

	// Position of one pixel in the frame, as the back end needs it
	typedef struct packed {
		logic first_col;
		logic row_nz;
		logic frame_end;
	} job_flags_t;

	// Exact floor(255 * (v/255)^2.2): largest k with k^10 * 255^12 <= v^22.
	// Evaluated at elaboration only.
	function automatic logic [255:0][7:0] build_lin();
		logic [255:0][7:0] rom;
		logic [191:0]      pv;
		logic [191:0]      q;
		int                k;
		logic              done;
		rom = '0;
		k = 0;
		for (int v = 0; v < 256; v++) begin
			pv = 192'd1;
			for (int i = 0; i < 22; i++) pv = pv * 192'(v);
			done = 1'b0;
			for (int n = 0; n < 256; n++) begin
				if (!done && k < 255) begin
					q = 192'd1;
					for (int i = 0; i < 10; i++) q = q * 192'(k + 1);
					for (int i = 0; i < 12; i++) q = q * 192'd255;
					if (q <= pv) k = k + 1;
					else done = 1'b1;
				end
			end
			rom[v] = 8'(k);
		end
		return rom;
	endfunction

	localparam logic [255:0][7:0] LinRom = build_lin();

endpackage

/* design/gsat_front.sv */
module gsat_front #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [gsat_pkg::CfgIndexW-1:0]      cfg_index,
	input  logic [gsat_pkg::CfgDataW-1:0]       cfg_data,
	input  logic                                in_valid,
	input  logic [7:0]                          red,
	input  logic [7:0]                          green,
	input  logic [7:0]                          blue,
	input  logic [7:0]                          alpha,
	output logic                                job_valid,
	input  logic                                job_ready,
	output gsat_pkg::lin_vec_t                  job_lin,
	output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] job_col,
	output gsat_pkg::job_flags_t                job_flags
);

	localparam int ColW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RowW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

	// Saturate a dimension to 1..max and return its last index
	function automatic logic [ColW-1:0] col_last(input logic [gsat_pkg::CfgDataW-1:0] v);
		logic [ColW-1:0] r;
		if (v == '0) r = '0;
		else if (32'(v) > 32'(MAX_WIDTH)) r = ColW'(MAX_WIDTH - 1);
		else r = ColW'(v - 1'b1);
		return r;
	endfunction

	function automatic logic [RowW-1:0] row_last(input logic [gsat_pkg::CfgDataW-1:0] v);
		logic [RowW-1:0] r;
		if (v == '0) r = '0;
		else if (32'(v) > 32'(MAX_HEIGHT)) r = RowW'(MAX_HEIGHT - 1);
		else r = RowW'(v - 1'b1);
		return r;
	endfunction

	logic [ColW-1:0] col_last_q;
	logic [RowW-1:0] row_last_q;
	logic [ColW-1:0] col_q;
	logic [RowW-1:0] row_q;
	logic            last_col;
	logic            last_row;
	logic            take;

	assign last_col = col_q >= col_last_q;
	assign last_row = row_q >= row_last_q;
	assign take     = in_valid && job_ready;

	assign job_valid           = in_valid;
	assign job_col             = col_q;
	assign job_flags.first_col = (col_q == '0);
	assign job_flags.row_nz    = (row_q != '0);
	assign job_flags.frame_end = last_col && last_row;
	assign job_lin[0]          = gsat_pkg::LinRom[red];
	assign job_lin[1]          = gsat_pkg::LinRom[green];
	assign job_lin[2]          = gsat_pkg::LinRom[blue];
	assign job_lin[3]          = gsat_pkg::LinRom[alpha];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_last_q <= col_last(12'd640);
			row_last_q <= row_last(12'd480);
			col_q      <= '0;
			row_q      <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					gsat_pkg::RegFrameWidth:  col_last_q <= col_last(cfg_data);
					gsat_pkg::RegFrameHeight: row_last_q <= row_last(cfg_data);
					default: ;
				endcase
			end
			if (take) begin
				if (last_col) begin
					col_q <= '0;
					// wrap the row counter on the last row of the frame
					if (last_row) row_q <= '0;
					else row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

endmodule

/* design/gsat_queue.sv */
module gsat_queue #(
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  logic [DATA_W-1:0] push_data,
	output logic              pop_valid,
	input  logic              pop_ready,
	output logic [DATA_W-1:0] pop_data
);

	logic [DATA_W-1:0] entry_q [2];
	logic              wr_q;
	logic              rd_q;
	logic [1:0]        count_q;
	logic              push;
	logic              pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = entry_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* design/gsat_back.sv */
module gsat_back #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 job_valid,
	output logic                 job_take,
	input  gsat_pkg::lin_vec_t   job_lin,
	input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] job_col,
	input  gsat_pkg::job_flags_t job_flags,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [31:0]          sum_red,
	output logic [31:0]          sum_green,
	output logic [31:0]          sum_blue,
	output logic [31:0]          sum_alpha,
	output logic                 frame_end
);

	localparam int ColW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	// Line store: previous row's table values, one entry per column
	gsat_pkg::sum_vec_t   line_mem [MAX_WIDTH];

	logic                 advance;
	logic                 valid_s1;
	gsat_pkg::lin_vec_t   lin_s1;
	logic [ColW-1:0]      col_s1;
	gsat_pkg::job_flags_t flags_s1;
	logic                 byp_s1;
	gsat_pkg::sum_vec_t   rd_s1;
	gsat_pkg::sum_vec_t   fwd_q;
	gsat_pkg::sum_vec_t   rowsum_q;
	gsat_pkg::sum_vec_t   row_next;
	gsat_pkg::sum_vec_t   above;
	gsat_pkg::sum_vec_t   total;
	gsat_pkg::sum_vec_t   sum_q;
	logic                 out_valid_q;
	logic                 frame_end_q;
	logic                 write;

	assign advance  = !out_valid_q || out_ready;
	assign job_take = advance;
	assign write    = advance && valid_s1;

	always_comb begin
		for (int c = 0; c < gsat_pkg::Channels; c++) begin
			if (!flags_s1.row_nz) above[c] = '0;
			else if (byp_s1) above[c] = fwd_q[c];
			else above[c] = rd_s1[c];
			if (flags_s1.first_col) row_next[c] = 32'(lin_s1[c]);
			else row_next[c] = rowsum_q[c] + 32'(lin_s1[c]);
			total[c] = row_next[c] + above[c];
		end
	end

	always_ff @(posedge clk) begin
		if (write) line_mem[col_s1] <= total;
	end

	always_ff @(posedge clk) begin
		if (advance && job_valid) rd_s1 <= line_mem[job_col];
	end

	always_ff @(posedge clk) begin
		if (advance && job_valid) begin
			lin_s1   <= job_lin;
			col_s1   <= job_col;
			flags_s1 <= job_flags;
		end
		if (write) begin
			fwd_q       <= total;
			sum_q       <= total;
			frame_end_q <= flags_s1.frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			byp_s1      <= 1'b0;
			out_valid_q <= 1'b0;
			rowsum_q    <= '0;
		end else if (advance) begin
			valid_s1    <= job_valid;
			// the entry being written this cycle is not yet visible to the read
			byp_s1      <= valid_s1 && (job_col == col_s1);
			out_valid_q <= valid_s1;
			if (valid_s1) rowsum_q <= row_next;
		end
	end

	assign out_valid = out_valid_q;
	assign sum_red   = sum_q[0];
	assign sum_green = sum_q[1];
	assign sum_blue  = sum_q[2];
	assign sum_alpha = sum_q[3];
	assign frame_end = frame_end_q;

endmodule

/* design/gamma_summed_area_table_top.sv */
// Channel  Handshake              Payload
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
// in       in_valid / in_ready    red, green, blue, alpha
// out      out_valid / out_ready  sum_red, sum_green, sum_blue, sum_alpha, frame_end
//
// One pixel per cycle while out_ready is high; each result is a registered output.
// The front end linearises and tags each pixel; a two-entry queue feeds the back end,
// which reads the line store, adds the row sum and registers the result.
// Reset clears counters and geometry (640 x 480); the line store is not cleared.
// Back-end stalls fill the queue, then drop in_ready; cfg_ready is always high.
module gamma_summed_area_table_top #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [gsat_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [gsat_pkg::CfgDataW-1:0]  cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     red,
	input  logic [7:0]                     green,
	input  logic [7:0]                     blue,
	input  logic [7:0]                     alpha,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [31:0]                    sum_red,
	output logic [31:0]                    sum_green,
	output logic [31:0]                    sum_blue,
	output logic [31:0]                    sum_alpha,
	output logic                           frame_end
);

	localparam int ColW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int FlagW  = $bits(gsat_pkg::job_flags_t);
	localparam int LinVW  = $bits(gsat_pkg::lin_vec_t);
	localparam int DataW  = LinVW + ColW + FlagW;

	logic                 push_valid;
	logic                 push_ready;
	gsat_pkg::lin_vec_t   push_lin;
	logic [ColW-1:0]      push_col;
	gsat_pkg::job_flags_t push_flags;
	logic                 pop_valid;
	logic                 pop_ready;
	logic [DataW-1:0]     pop_data;
	gsat_pkg::lin_vec_t   pop_lin;
	logic [ColW-1:0]      pop_col;
	gsat_pkg::job_flags_t pop_flags;

	assign cfg_ready = 1'b1;
	assign in_ready  = push_ready;

	gsat_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.alpha     (alpha),
		.job_valid (push_valid),
		.job_ready (push_ready),
		.job_lin   (push_lin),
		.job_col   (push_col),
		.job_flags (push_flags)
	);

	gsat_queue #(
		.DATA_W (DataW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  ({push_lin, push_col, push_flags}),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	assign pop_lin   = pop_data[DataW-1 -: LinVW];
	assign pop_col   = pop_data[FlagW +: ColW];
	assign pop_flags = pop_data[FlagW-1:0];

	gsat_back #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (pop_valid),
		.job_take  (pop_ready),
		.job_lin   (pop_lin),
		.job_col   (pop_col),
		.job_flags (pop_flags),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sum_red   (sum_red),
		.sum_green (sum_green),
		.sum_blue  (sum_blue),
		.sum_alpha (sum_alpha),
		.frame_end (frame_end)
	);

endmodule

/* design/gsat_checker.sv */
module gsat_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] sum_red,
	input logic        frame_end
);

	logic [2:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// items taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 3'd0;
		end else begin
			case ({in_acc, out_acc})
				2'b10:   pend_q <= pend_q + 3'd1;
				2'b01:   pend_q <= pend_q - 3'd1;
				default: pend_q <= pend_q;
			endcase
		end
	end

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 3'd0)
		else $error("result shown with no item in flight");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd4)
		else $error("more items in flight than the datapath can hold");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(sum_red) && $stable(frame_end))
		else $error("result changed while stalled");

endmodule

bind gamma_summed_area_table_top gsat_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.sum_red   (sum_red),
	.frame_end (frame_end)
);

/* test/gsat_area_checker.sv */
`timescale 1ns / 1ps

module gsat_area_checker #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [gsat_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [gsat_pkg::CfgDataW-1:0]  cfg_data,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic [7:0]                     red,
	input  logic [7:0]                     green,
	input  logic [7:0]                     blue,
	input  logic [7:0]                     alpha,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [31:0]                    sum_red,
	input  logic [31:0]                    sum_green,
	input  logic [31:0]                    sum_blue,
	input  logic [31:0]                    sum_alpha,
	input  logic                           frame_end,
	output int                             fail_count,
	output int                             outstanding
);

	typedef struct packed {
		gsat_pkg::sum_vec_t sums;
		logic               frame_end;
	} area_result_t;

	string chan_name [4] = '{"sum_red", "sum_green", "sum_blue", "sum_alpha"};

	logic [7:0]         lin_lut [256];
	logic [11:0]        width_reg = 12'd640;
	logic [11:0]        height_reg = 12'd480;
	int unsigned        col_at;
	int unsigned        row_at;
	gsat_pkg::sum_vec_t row_sum;
	gsat_pkg::sum_vec_t line_store [MAX_WIDTH];
	area_result_t       pending_sums [$];
	int                 mismatches = 0;

	assign fail_count = mismatches;

	function automatic logic [191:0] ipow(input int unsigned base_v, input int n);
		logic [191:0] acc;
		acc = 192'd1;
		for (int i = 0; i < n; i++) acc = acc * 192'(base_v);
		return acc;
	endfunction

	// Gamma table: largest k with k^10 * 255^12 <= v^22, found bit by bit
	initial begin : build_lut
		logic [191:0] target;
		int unsigned  k;
		int unsigned  cand;
		for (int v = 0; v < 256; v++) begin
			target = ipow(v, 22);
			k = 0;
			for (int b = 7; b >= 0; b--) begin
				cand = k | (32'd1 << b);
				if (ipow(cand, 10) * ipow(255, 12) <= target) k = cand;
			end
			lin_lut[v] = 8'(k);
		end
	end

	function automatic int unsigned clamp_dim(input logic [11:0] x, input int unsigned hi);
		if (x == 12'd0) return 1;
		if (x > hi) return hi;
		return x;
	endfunction

	task automatic integrate_pixel(input logic [3:0][7:0] raw, output area_result_t res);
		int unsigned w;
		int unsigned h;
		logic        last_col;
		logic        last_row;
		logic [31:0] above;
		w = clamp_dim(width_reg, MAX_WIDTH);
		h = clamp_dim(height_reg, MAX_HEIGHT);
		last_col = (col_at >= w - 1);
		last_row = (row_at >= h - 1);
		for (int c = 0; c < 4; c++) begin
			if (col_at == 0) row_sum[c] = 32'(lin_lut[raw[c]]);
			else row_sum[c] = row_sum[c] + 32'(lin_lut[raw[c]]);
			// the first row of a frame has nothing above it
			above = (row_at > 0 && col_at < MAX_WIDTH) ? line_store[col_at][c] : 32'd0;
			res.sums[c] = row_sum[c] + above;
			if (col_at < MAX_WIDTH) line_store[col_at][c] = res.sums[c];
		end
		res.frame_end = last_col && last_row;
		if (last_col) begin
			col_at = 0;
			row_at = last_row ? 0 : row_at + 1;
		end else begin
			col_at = col_at + 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track_pixels
		area_result_t want;
		area_result_t got;
		if (!arst_n) begin
			width_reg = 12'd640;
			height_reg = 12'd480;
			col_at = 0;
			row_at = 0;
			row_sum = '0;
			pending_sums.delete();
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					gsat_pkg::RegFrameWidth:  width_reg = cfg_data;
					gsat_pkg::RegFrameHeight: height_reg = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				integrate_pixel({alpha, blue, green, red}, want);
				pending_sums.push_back(want);
			end
			if (out_valid && out_ready) begin
				got.sums = {sum_alpha, sum_blue, sum_green, sum_red};
				got.frame_end = frame_end;
				if (pending_sums.size() == 0) begin
					$error("unexpected result: sum_red %0d, frame_end %0b", sum_red, frame_end);
					mismatches++;
				end else begin
					want = pending_sums.pop_front();
					for (int c = 0; c < 4; c++) begin
						if (got.sums[c] !== want.sums[c]) begin
							$error("%s: expected %0d, got %0d", chan_name[c], want.sums[c],
								got.sums[c]);
							mismatches++;
						end
					end
					if (got.frame_end !== want.frame_end) begin
						$error("frame_end: expected %0b, got %0b", want.frame_end, got.frame_end);
						mismatches++;
					end
				end
			end
			outstanding <= pending_sums.size();
		end
	end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

	localparam int         MaxDim        = 2048;
	localparam int         RandomItems   = 1080;
	localparam int         SettleCycles  = 8;
	localparam int         WatchdogLimit = 5000;
	localparam logic [1:0] RegSpareA     = 2'd2;
	localparam logic [1:0] RegSpareB     = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [11:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  alpha;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] sum_red;
	logic [31:0] sum_green;
	logic [31:0] sum_blue;
	logic [31:0] sum_alpha;
	logic        frame_end;
	int          fail_count;
	int          outstanding;

	// stimulus-side view of the geometry and raster position
	logic [11:0] shadow_w = 12'd640;
	logic [11:0] shadow_h = 12'd480;
	int          col_pos = 0;
	int          row_pos = 0;
	int          widest = 0;
	int          frames_done = 0;
	int          pixels_sent = 0;
	int          reg_writes = 0;
	int          random_sent = 0;
	int          corner_idx = 0;
	int          ready_hold = 0;
	int          quiet = 0;
	bit          calm = 1'b0;

	gamma_summed_area_table_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.alpha     (alpha),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sum_red   (sum_red),
		.sum_green (sum_green),
		.sum_blue  (sum_blue),
		.sum_alpha (sum_alpha),
		.frame_end (frame_end)
	);

	gsat_area_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.alpha       (alpha),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.sum_red     (sum_red),
		.sum_green   (sum_green),
		.sum_blue    (sum_blue),
		.sum_alpha   (sum_alpha),
		.frame_end   (frame_end),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int eff_dim(input logic [11:0] x);
		if (x == 12'd0) return 1;
		if (x > 12'(MaxDim)) return MaxDim;
		return x;
	endfunction

	// mostly short, now and then long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) return $urandom_range(1, 3);
		if (r < 95) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] corner_byte(input int i);
		case (i)
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'd20;
			3: return 8'd21;
			4: return 8'd1;
			5: return 8'd128;
			6: return 8'd254;
			7: return 8'hAA;
			default: return 8'h55;
		endcase
	endfunction

	function automatic logic [7:0] rand_byte();
		if ($urandom_range(0, 9) == 0) return corner_byte($urandom_range(0, 8));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [11:0] wide_value();
		case ($urandom_range(0, 3))
			0: return 12'd2047;
			1: return 12'd2048;
			2: return 12'd2049;
			default: return 12'd4095;
		endcase
	endfunction

	task automatic push_pixel(input logic [7:0] r, g, b, a);
		int gap;
		int w;
		int h;
		gap = (!calm && $urandom_range(0, 99) < 30) ? idle_len() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		red <= r;
		green <= g;
		blue <= b;
		alpha <= a;
		do @(posedge clk); while (!in_ready);
		pixels_sent++;
		w = eff_dim(shadow_w);
		h = eff_dim(shadow_h);
		if (col_pos + 1 > widest) widest = col_pos + 1;
		if (col_pos >= w - 1) begin
			col_pos = 0;
			if (row_pos >= h - 1) begin
				row_pos = 0;
				frames_done++;
			end else begin
				row_pos++;
			end
		end else begin
			col_pos++;
		end
	endtask

	task automatic send_directed(input int n);
		for (int i = 0; i < n; i++) begin
			push_pixel(corner_byte(corner_idx % 9), corner_byte((corner_idx + 3) % 9),
				corner_byte((corner_idx + 5) % 9), corner_byte((corner_idx + 7) % 9));
			corner_idx++;
		end
	endtask

	task automatic send_random(input int n);
		for (int i = 0; i < n; i++) push_pixel(rand_byte(), rand_byte(), rand_byte(), rand_byte());
	endtask

	// drop valid and wait until every item has come out
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [11:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		reg_writes++;
		if (idx == gsat_pkg::RegFrameWidth) shadow_w = value;
		else if (idx == gsat_pkg::RegFrameHeight) shadow_h = value;
	endtask

	task automatic configure(input logic [11:0] w, h, input bit do_w, do_h, stray);
		settle();
		if (do_w) write_reg(gsat_pkg::RegFrameWidth, w);
		if (do_h) write_reg(gsat_pkg::RegFrameHeight, h);
		if (stray) write_reg($urandom_range(0, 1) ? RegSpareA : RegSpareB, 12'($urandom));
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
			out_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 99) < 20) begin
			ready_hold <= idle_len() - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet >= WatchdogLimit) begin
			$display("watchdog: no item moved for %0d cycles", quiet);
			$display("tb_top: FAIL");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		int          r;
		int          n;
		logic [11:0] new_w;
		logic [11:0] new_h;
		bit          do_w;
		bit          do_h;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		red = '0;
		green = '0;
		blue = '0;
		alpha = '0;
		out_ready = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset geometry, then zero sizes, a small frame, and mid-frame shrinking
		send_directed(3);
		configure(12'd0, 12'd0, 1'b1, 1'b1, 1'b0);
		send_directed(1);
		configure(12'd3, 12'd3, 1'b1, 1'b1, 1'b1);
		send_directed(9);
		configure(12'd4, 12'd4, 1'b1, 1'b1, 1'b0);
		send_directed(6);
		configure(12'd2, 12'd1, 1'b1, 1'b1, 1'b0);
		send_directed(1);

		// saturated width cut short mid-row, then a saturated height at width one
		configure(12'd4095, 12'd2, 1'b1, 1'b1, 1'b0);
		send_random(48);
		configure(12'd1, 12'd4095, 1'b1, 1'b1, 1'b0);
		send_random(48);

		while (random_sent < RandomItems) begin
			calm = ($urandom_range(0, 4) == 0);
			r = $urandom_range(0, 99);
			if (r < 70) begin
				new_w = 12'($urandom_range(1, 16));
				new_h = 12'($urandom_range(1, 8));
			end else if (r < 85) begin
				new_w = 12'($urandom_range(17, 80));
				new_h = 12'($urandom_range(1, 4));
			end else if (r < 92) begin
				new_w = wide_value();
				new_h = 12'($urandom_range(0, 3));
			end else if (r < 97) begin
				new_w = 12'($urandom_range(0, 4));
				new_h = wide_value();
			end else begin
				new_w = 12'($urandom);
				new_h = 12'($urandom_range(0, 3));
			end
			do_w = ($urandom_range(0, 3) != 0);
			do_h = ($urandom_range(0, 3) != 0);
			// never widen past columns the line store has seen while rows above are read
			if (do_w && row_pos != 0 && eff_dim(new_w) > widest) new_w = 12'(widest);
			configure(new_w, new_h, do_w, do_h, $urandom_range(0, 9) == 0);
			n = $urandom_range(10, 120);
			send_random(n);
			random_sent += n;
		end

		calm = 1'b0;
		settle();
		$display("summary: %0d pixels, %0d complete frames, %0d register writes",
			pixels_sent, frames_done, reg_writes);
		$display("summary: sizes from 1 to 2048 incl. zero and saturated, mid-frame geometry changes");
		if (fail_count == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
